>>> rtl/fpscam_pkg.sv
package fpscam_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int TabLen = 24;

    localparam int AngW  = 27;
    localparam int VecW  = 34;
    localparam int Q14W  = 16;
    localparam int PosW  = 32;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] RegMouseSpeed = 3'd0;
    localparam logic [CfgIdxW-1:0] RegStartYaw   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegStartPitch = 3'd2;
    localparam logic [CfgIdxW-1:0] RegStartPosX  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegStartPosY  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegStartPosZ  = 3'd5;

    localparam logic signed [35:0] YawMod    = 36'sd23592960;
    localparam logic signed [35:0] PitchLim  = 36'sd5832704;
    localparam logic signed [AngW-1:0] Deg90  = 27'sd5898240;
    localparam logic signed [AngW-1:0] Deg180 = 27'sd11796480;
    localparam logic signed [VecW-1:0] CordicGain = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic signed [31:0] delta_pos_x;
        logic signed [31:0] delta_pos_y;
        logic signed [31:0] delta_pos_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] back_x;
        logic signed [15:0] back_y;
        logic signed [15:0] back_z;
        logic signed [31:0] trans_right;
        logic signed [31:0] trans_up;
        logic signed [31:0] trans_fwd;
    } t_out;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [31:0]        data;
    } t_cfg;

    function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] i);
        logic signed [AngW-1:0] r;
        unique case (i)
            5'd0: r = 27'sd2949120;  5'd1: r = 27'sd1740967;
            5'd2: r = 27'sd919879;   5'd3: r = 27'sd466945;
            5'd4: r = 27'sd234379;   5'd5: r = 27'sd117304;
            5'd6: r = 27'sd58666;    5'd7: r = 27'sd29335;
            5'd8: r = 27'sd14668;    5'd9: r = 27'sd7334;
            5'd10: r = 27'sd3667;    5'd11: r = 27'sd1833;
            5'd12: r = 27'sd917;     5'd13: r = 27'sd458;
            5'd14: r = 27'sd229;     5'd15: r = 27'sd115;
            5'd16: r = 27'sd57;      5'd17: r = 27'sd29;
            5'd18: r = 27'sd14;      5'd19: r = 27'sd7;
            5'd20: r = 27'sd4;       5'd21: r = 27'sd2;
            5'd22: r = 27'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/fpscam_if.sv
interface fpscam_in_if;
    logic             valid;
    logic             ready;
    fpscam_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpscam_out_if;
    logic             valid;
    logic             ready;
    fpscam_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpscam_cfg_if;
    logic             valid;
    logic             ready;
    fpscam_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fpscam_cordic.sv
module fpscam_cordic #(
    parameter int CORDIC_STEPS = fpscam_pkg::CordicStepsDefault
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [fpscam_pkg::AngW-1:0]     i_angle,
    output logic                                   o_done,
    output logic signed [fpscam_pkg::VecW-1:0]     o_sin,
    output logic signed [fpscam_pkg::VecW-1:0]     o_cos
);
    localparam int NSteps = (CORDIC_STEPS < fpscam_pkg::TabLen) ?
                            CORDIC_STEPS : fpscam_pkg::TabLen;

    logic                                r_busy;
    logic [4:0]                          r_step;
    logic                                r_neg;
    logic signed [fpscam_pkg::VecW-1:0]  r_x, r_y;
    logic signed [fpscam_pkg::AngW-1:0]  r_z;
    logic signed [fpscam_pkg::AngW-1:0]  a1, a2;
    logic                                neg;
    logic signed [fpscam_pkg::VecW-1:0]  xs, ys;

    always_comb begin
        a1 = i_angle;
        if (a1 > fpscam_pkg::Deg180) begin
            a1 = a1 - fpscam_pkg::AngW'(fpscam_pkg::YawMod);
        end
        a2 = a1;
        neg = 1'b0;
        if (a1 > fpscam_pkg::Deg90) begin
            a2 = a1 - fpscam_pkg::Deg180;
            neg = 1'b1;
        end else if (a1 < -fpscam_pkg::Deg90) begin
            a2 = a1 + fpscam_pkg::Deg180;
            neg = 1'b1;
        end
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == 5'(NSteps - 1)) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= fpscam_pkg::CordicGain;
            r_y   <= '0;
            r_z   <= a2;
            r_neg <= neg;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - fpscam_pkg::atan_deg(r_step);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + fpscam_pkg::atan_deg(r_step);
            end
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_sin  = r_neg ? -r_y : r_y;
    assign o_cos  = r_neg ? -r_x : r_x;
endmodule

>>> rtl/fps_camera_view_matrix_top.sv
// Camera view-matrix unit. Each request runs the pitch update and a yaw
// reduction by reciprocal multiplication in two steps (StWr1, StWr2), then
// two sequential CORDIC passes of CORDIC_STEPS iterations, capped at TabLen,
// on a shared unit. It finishes with thirteen multiply steps on two shared
// multipliers. The result is held in an output register, and the next request
// is taken once it has been delivered. A configuration write has priority over
// a request offered in the same cycle.
module fps_camera_view_matrix_top #(
    parameter int CORDIC_STEPS = fpscam_pkg::CordicStepsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fpscam_in_if.sink   in_ch,
    fpscam_out_if.source out_ch,
    fpscam_cfg_if.sink  cfg_ch
);
    localparam logic [3:0] StIdle = 4'd0, StUpd = 4'd1, StYaw = 4'd2,
        StYawW = 4'd3, StPit = 4'd4, StPitW = 4'd5, StMul = 4'd6,
        StOut = 4'd7, StWr1 = 4'd8, StWr2 = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_speed;
    logic signed [35:0] r_yaw, r_pitch;
    logic signed [36:0] r_ysum;
    logic [11:0] r_q;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_dx, r_dy;
    logic signed [fpscam_pkg::VecW-1:0] r_sy, r_cy, r_sp, r_cp;
    logic [3:0] r_k;
    logic signed [49:0] r_acc;
    logic signed [15:0] r_ux, r_uz, r_bx, r_bz;
    fpscam_pkg::t_out r_out;
    logic r_ovalid;

    logic cs_start, cs_done;
    logic signed [fpscam_pkg::AngW-1:0] cs_angle;
    logic signed [fpscam_pkg::VecW-1:0] cs_sin, cs_cos;

    fpscam_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk, .i_rst_n, .i_start(cs_start), .i_angle(cs_angle),
        .o_done(cs_done), .o_sin(cs_sin), .o_cos(cs_cos)
    );

    function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + 36'sd32768) >>> 16;
        if (r > 36'sd16384) r = 36'sd16384;
        if (r < -36'sd16384) r = -36'sd16384;
        return 16'(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] s);
        logic signed [49:0] r;
        r = -((s + 50'sd8192) >>> 14);
        if (r > 50'sd2147483647) r = 50'sd2147483647;
        if (r < -50'sd2147483648) r = -50'sd2147483648;
        return 32'(r);
    endfunction

    // Shared multiplier operands, chosen per step.
    logic signed [fpscam_pkg::VecW-1:0] ma, mb;
    logic signed [67:0] prod;
    logic signed [35:0] p30;
    logic signed [15:0] qa;
    logic signed [31:0] qb;
    logic signed [47:0] qprod;
    always_comb begin
        unique case (r_k)
            4'd0: begin ma = r_cy; mb = r_sp; end
            4'd1: begin ma = r_sy; mb = r_sp; end
            4'd2: begin ma = r_cp; mb = r_cy; end
            4'd3: begin ma = r_cp; mb = r_sy; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = 68'(ma) * 68'(mb);
        p30  = 36'((prod + 68'sd536870912) >>> 30);
        unique case (r_k)
            4'd4: begin qa = r_out.right_x; qb = r_px; end
            4'd5: begin qa = r_out.right_z; qb = r_pz; end
            4'd6: begin qa = r_ux; qb = r_px; end
            4'd7: begin qa = r_out.up_y; qb = r_py; end
            4'd8: begin qa = r_uz; qb = r_pz; end
            4'd9: begin qa = r_bx; qb = r_px; end
            4'd10: begin qa = r_out.back_y; qb = r_py; end
            4'd11: begin qa = r_bz; qb = r_pz; end
            default: begin qa = '0; qb = '0; end
        endcase
        qprod = 48'(qa) * 48'(qb);
    end

    // Yaw is reduced modulo 45 * 2^19 (360 degrees): the whole multiples of
    // 2^19 are offset to be positive and divided by 45 through a reciprocal.
    logic signed [36:0] dly, dlp, ysum, pa;
    logic signed [17:0] yt;
    logic [17:0] yu, yrem;
    logic [27:0] yprod;
    logic signed [35:0] yfin;
    always_comb begin
        dly = 37'(r_dx) * 37'($signed({1'b0, r_speed})) * 37'sd16;
        dlp = 37'(r_dy) * 37'($signed({1'b0, r_speed})) * 37'sd16;
        ysum = 37'(r_yaw) + dly;
        pa = 37'(r_pitch) + dlp;
        if (pa > 37'(fpscam_pkg::PitchLim)) pa = 37'(fpscam_pkg::PitchLim);
        if (pa < -37'(fpscam_pkg::PitchLim)) pa = -37'(fpscam_pkg::PitchLim);
        yt = 18'(r_ysum >>> 19);
        yu = 18'($unsigned(yt)) + 18'd67500;
        yprod = 28'(yu) * 28'd1456;
        yrem = yu - 18'(r_q) * 18'd45;
        if (yrem >= 18'd45) yrem = yrem - 18'd45;
        yfin = 36'({yrem[5:0], r_ysum[18:0]});
    end

    assign cs_start = (r_state == StYaw) || (r_state == StPit);
    assign cs_angle = (r_state == StYaw) ? fpscam_pkg::AngW'(r_yaw)
                                         : fpscam_pkg::AngW'(r_pitch);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            StIdle: if (in_ch.valid && in_ch.ready) n_state = StUpd;
            StUpd:  n_state = StWr1;
            StWr1:  n_state = StWr2;
            StWr2:  n_state = StYaw;
            StYaw:  n_state = StYawW;
            StYawW: if (cs_done) n_state = StPit;
            StPit:  n_state = StPitW;
            StPitW: if (cs_done) n_state = StMul;
            StMul:  if (r_k == 4'd12) n_state = StOut;
            StOut:  if (!r_ovalid) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    assign in_ch.ready  = (r_state == StIdle) && !cfg_ch.valid;
    assign cfg_ch.ready = (r_state == StIdle);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    logic signed [35:0] ymod;
    always_comb begin
        ymod = 36'(cfg_ch.data.data[24:0]);
        if (ymod >= fpscam_pkg::YawMod) ymod = ymod - fpscam_pkg::YawMod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_ovalid <= 1'b0;
            r_speed  <= 16'd4096;
            r_yaw    <= '0;
            r_pitch  <= '0;
            r_px <= '0; r_py <= '0; r_pz <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (cfg_ch.valid && cfg_ch.ready) begin
                unique case (cfg_ch.data.index)
                    fpscam_pkg::RegMouseSpeed: r_speed <= cfg_ch.data.data[15:0];
                    fpscam_pkg::RegStartYaw: r_yaw <= ymod;
                    fpscam_pkg::RegStartPitch: begin
                        if ($signed(cfg_ch.data.data[23:0]) > 24'sd5832704)
                            r_pitch <= fpscam_pkg::PitchLim;
                        else if ($signed(cfg_ch.data.data[23:0]) < -24'sd5832704)
                            r_pitch <= -fpscam_pkg::PitchLim;
                        else r_pitch <= 36'($signed(cfg_ch.data.data[23:0]));
                    end
                    fpscam_pkg::RegStartPosX: r_px <= cfg_ch.data.data;
                    fpscam_pkg::RegStartPosY: r_py <= cfg_ch.data.data;
                    fpscam_pkg::RegStartPosZ: r_pz <= cfg_ch.data.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                StIdle: if (in_ch.valid && in_ch.ready) begin
                    r_dx <= in_ch.data.mouse_dx;
                    r_dy <= in_ch.data.mouse_dy;
                    r_px <= r_px + in_ch.data.delta_pos_x;
                    r_py <= r_py + in_ch.data.delta_pos_y;
                    r_pz <= r_pz + in_ch.data.delta_pos_z;
                end
                StUpd: begin
                    r_ysum <= ysum;
                    r_pitch <= 36'(pa);
                end
                StWr1: r_q <= yprod[27:16];
                StWr2: r_yaw <= yfin;
                StYawW: if (cs_done) begin
                    r_sy <= cs_sin; r_cy <= cs_cos;
                end
                StPitW: if (cs_done) begin
                    r_sp <= cs_sin; r_cp <= cs_cos;
                    r_out.right_x <= to_q14(-36'(r_sy));
                    r_out.right_z <= to_q14(36'(r_cy));
                    r_out.up_y    <= to_q14(36'(cs_cos));
                    r_out.back_y  <= to_q14(-36'(cs_sin));
                    r_k <= '0;
                    r_acc <= '0;
                end
                StMul: begin
                    r_k <= r_k + 4'd1;
                    unique case (r_k)
                        4'd0: r_ux <= to_q14(-p30);
                        4'd1: r_uz <= to_q14(-p30);
                        4'd2: r_bx <= to_q14(-p30);
                        4'd3: r_bz <= to_q14(-p30);
                        default: ;
                    endcase
                    if (r_k == 4'd6 || r_k == 4'd9 || r_k == 4'd4)
                        r_acc <= 50'(qprod);
                    else if (r_k >= 4'd4)
                        r_acc <= r_acc + 50'(qprod);
                    if (r_k == 4'd6) r_out.trans_right <= sat32(r_acc);
                    if (r_k == 4'd9) r_out.trans_up <= sat32(r_acc);
                    if (r_k == 4'd12) begin
                        r_out.trans_fwd <= sat32(r_acc);
                        r_out.up_x <= r_ux; r_out.up_z <= r_uz;
                        r_out.back_x <= r_bx; r_out.back_z <= r_bz;
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/fpscam_checker.sv
module fpscam_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_ready
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after request");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> cfg_ready) else $error("config ready mismatch");
endmodule

bind fps_camera_view_matrix_top fpscam_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cfg_ready(cfg_ch.ready)
);
